### hdl/ilir_pkg.sv
// shared types and constants for the indexed list with insert and remove
`default_nettype none
package ilir_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = 7;
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STAT_W   = 2;

   localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic        [MODE_W-1:0] mode;
      logic        [IDX_W-1:0]  index;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic        [STAT_W-1:0] status;
      logic        [CNT_W-1:0]  count;
   } rsp_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic                     write;
      logic                     shift_up;
      logic                     shift_down;
      logic        [IDX_W-1:0]  pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage
`default_nettype wire

### hdl/ilir_cell.sv
// one list entry: loads, shifts from a neighbor and taps the read bus
`default_nettype none
module ilir_cell (
   input  wire logic                             clock,
   input  wire logic [ilir_pkg::IDX_W-1:0]       cell_index,
   input  wire ilir_pkg::cell_cmd_type           cmd,
   input  wire logic signed [ilir_pkg::DATA_W-1:0] below_data,
   input  wire logic signed [ilir_pkg::DATA_W-1:0] above_data,
   output logic signed [ilir_pkg::DATA_W-1:0]    entry_data,
   output logic signed [ilir_pkg::DATA_W-1:0]    read_tap
);
   import ilir_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     at_pos;
   logic                     past_pos;

   assign at_pos   = (cell_index == cmd.pos);
   assign past_pos = (cell_index > cmd.pos);

   always_comb begin
      data_in = data_ff;
      if (cmd.shift_down && (at_pos || past_pos)) begin
         data_in = above_data;
      end else if (cmd.shift_up && past_pos) begin
         data_in = below_data;
      end else if (cmd.write && at_pos) begin
         data_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry_data = data_ff;
   assign read_tap   = at_pos ? data_ff : '0;

endmodule
`default_nettype wire

### hdl/indexed_list_insert_remove.sv
// top level: row of list cells, length counter and result register
// the result of a transaction is offered in the cycle after acceptance
// throughput: one transaction per cycle unless a held result stalls; insert
// and remove move cells from the index up in that cycle, each from a neighbor
// reset clears the length and the result valid; cell contents are not cleared
`default_nettype none
module indexed_list_insert_remove (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ilir_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ilir_pkg::rsp_type      rsp_payload
);
   import ilir_pkg::*;

   logic [CNT_W-1:0]         length_ff;
   logic [CNT_W-1:0]         length_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   cell_cmd_type             cmd;
   logic                     accept;
   logic                     needs_index;
   logic                     range_err;
   logic                     full_err;
   logic                     is_read;
   logic                     is_write;
   logic                     is_append;
   logic                     is_insert;
   logic                     is_remove;
   logic signed [DATA_W-1:0] entry_bus [CAPACITY];
   logic signed [DATA_W-1:0] tap_bus   [CAPACITY];
   logic signed [DATA_W-1:0] read_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_read   = (req_payload.mode == MODE_READ);
   assign is_write  = (req_payload.mode == MODE_WRITE);
   assign is_append = (req_payload.mode == MODE_APPEND);
   assign is_insert = (req_payload.mode == MODE_INSERT);
   assign is_remove = (req_payload.mode == MODE_REMOVE);

   assign needs_index = is_read || is_write || is_insert || is_remove;
   assign range_err   = needs_index && ({1'b0, req_payload.index} >= length_ff);
   assign full_err    = !range_err && (is_append || is_insert)
                        && (length_ff == CNT_W'(CAPACITY));

   always_comb begin
      cmd.write      = accept && !range_err && !full_err
                       && (is_write || is_append || is_insert);
      cmd.shift_up   = accept && !range_err && !full_err && is_insert;
      cmd.shift_down = accept && !range_err && is_remove;
      cmd.pos        = is_append ? length_ff[IDX_W-1:0] : req_payload.index;
      cmd.value      = req_payload.value;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      ilir_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .cmd        (cmd),
         .below_data ((i == 0) ? entry_bus[i] : entry_bus[(i == 0) ? 0 : i - 1]),
         .above_data ((i == CAPACITY - 1) ? entry_bus[i]
                                          : entry_bus[(i == CAPACITY - 1) ? i : i + 1]),
         .entry_data (entry_bus[i]),
         .read_tap   (tap_bus[i])
      );
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_data = read_data | tap_bus[i];
      end
   end

   always_comb begin
      length_in = length_ff;
      if (cmd.write && (is_append || is_insert)) begin
         length_in = length_ff + CNT_W'(1);
      end else if (cmd.shift_down) begin
         length_in = length_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_in.count  = length_in;
         rsp_in.status = range_err ? ST_RANGE : (full_err ? ST_FULL : ST_OK);
         rsp_in.data   = (!range_err && (is_read || is_remove)) ? read_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
